FILE: rtl/mkne_pkg.sv
// shared types, constants and key table for the keypad number entry block
`timescale 1ns / 1ps
`default_nettype none
package mkne_pkg;

  localparam logic [3:0] ALL_HIGH  = 4'hF;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [7:0] CHAR_STAR = 8'h2A;
  localparam logic [7:0] CHAR_HASH = 8'h23;

  typedef struct packed {
    logic        echo_valid;
    logic [7:0]  echo_char;
    logic        number_done;
    logic [31:0] number_value;
  } acc_res_t;

  function automatic logic [7:0] key_lookup(input logic [1:0] row, input logic [1:0] col);
    logic [7:0] k;
    unique case ({row, col})
      4'h0: k = 8'h31;
      4'h1: k = 8'h32;
      4'h2: k = 8'h33;
      4'h3: k = 8'h41;
      4'h4: k = 8'h34;
      4'h5: k = 8'h35;
      4'h6: k = 8'h36;
      4'h7: k = 8'h42;
      4'h8: k = 8'h37;
      4'h9: k = 8'h38;
      4'hA: k = 8'h39;
      4'hB: k = 8'h43;
      4'hC: k = CHAR_STAR;
      4'hD: k = CHAR_ZERO;
      4'hE: k = CHAR_HASH;
      default: k = 8'h44;
    endcase
    return k;
  endfunction

  function automatic logic [1:0] first_low_column(input logic [3:0] cols);
    logic [1:0] c;
    if (!cols[0]) c = 2'd0;
    else if (!cols[1]) c = 2'd1;
    else if (!cols[2]) c = 2'd2;
    else c = 2'd3;
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/matrix_keypad_number_entry.sv
// 4x4 matrix keypad scanner with decimal number entry, top level
// each accepted transaction's result is registered in the output register
// throughput: one transaction per cycle while in_stall is low; the output register frees while it is taken
// in_stall is raised only while a result waits and out_stall is high
// reset (synchronous, active low): wait for press, row 0, held key and number zero,
// echo_digits 0, no result pending
`timescale 1ns / 1ps
`default_nettype none
module matrix_keypad_number_entry #(
  parameter int NUMBER_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [3:0]  in_column_levels,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       out_row_drive,
  output logic             out_key_valid,
  output logic [7:0]       out_key_code,
  output logic             out_echo_valid,
  output logic [7:0]       out_echo_char,
  output logic             out_number_done,
  output logic [31:0]      out_number_value,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_echo_digits
);

  typedef enum logic [1:0] {
    PH_WAIT    = 2'd0,
    PH_SEARCH  = 2'd1,
    PH_RELEASE = 2'd2
  } phase_t;

  phase_t                  phase_r, phase_nxt;
  logic [1:0]              row_r, row_nxt;
  logic [7:0]              held_r, held_nxt;
  logic [NUMBER_WIDTH-1:0] num_r, num_nxt;
  logic                    echo_digits_r;
  logic                    out_valid_r;
  logic [3:0]              row_drive_r, row_drive_nxt;
  logic                    key_valid_r, key_valid_nxt;
  logic [7:0]              key_code_r, key_code_nxt;
  mkne_pkg::acc_res_t      acc_r, acc_nxt;
  logic                    accept;
  logic                    pressed;
  logic                    release_ev;

  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign pressed   = in_column_levels != mkne_pkg::ALL_HIGH;

  always_comb begin
    phase_nxt     = phase_r;
    row_nxt       = row_r;
    held_nxt      = held_r;
    row_drive_nxt = 4'h0;
    key_valid_nxt = 1'b0;
    key_code_nxt  = 8'h00;
    release_ev    = 1'b0;
    unique case (phase_r)
      PH_SEARCH: begin
        if (pressed) begin
          held_nxt  = mkne_pkg::key_lookup(row_r,
                                           mkne_pkg::first_low_column(in_column_levels));
          phase_nxt = PH_RELEASE;
        end else if (row_r == 2'd3) begin
          row_nxt   = 2'd0;
          phase_nxt = PH_WAIT;
        end else begin
          row_nxt       = row_r + 2'd1;
          row_drive_nxt = ~(4'b0001 << (row_r + 2'd1));
        end
      end
      PH_RELEASE: begin
        if (!pressed) begin
          release_ev    = 1'b1;
          key_valid_nxt = 1'b1;
          key_code_nxt  = held_r;
          phase_nxt     = PH_WAIT;
        end
      end
      default: begin
        phase_nxt = PH_WAIT;
        if (pressed) begin
          row_nxt       = 2'd0;
          phase_nxt     = PH_SEARCH;
          row_drive_nxt = 4'b1110;
        end
      end
    endcase
  end

  mkne_accum #(
    .NUMBER_WIDTH(NUMBER_WIDTH)
  ) u_accum (
    .key_en      (release_ev),
    .key         (held_r),
    .echo_digits (echo_digits_r),
    .num         (num_r),
    .num_nxt     (num_nxt),
    .res         (acc_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_WAIT;
      row_r         <= 2'd0;
      held_r        <= 8'h00;
      num_r         <= '0;
      echo_digits_r <= 1'b0;
      out_valid_r   <= 1'b0;
      row_drive_r   <= 4'h0;
      key_valid_r   <= 1'b0;
      key_code_r    <= 8'h00;
      acc_r         <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        echo_digits_r <= cfg_echo_digits;
      end
      if (accept) begin
        phase_r     <= phase_nxt;
        row_r       <= row_nxt;
        held_r      <= held_nxt;
        num_r       <= num_nxt;
        out_valid_r <= 1'b1;
        row_drive_r <= row_drive_nxt;
        key_valid_r <= key_valid_nxt;
        key_code_r  <= key_code_nxt;
        acc_r       <= acc_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_row_drive    = row_drive_r;
  assign out_key_valid    = key_valid_r;
  assign out_key_code     = key_code_r;
  assign out_echo_valid   = acc_r.echo_valid;
  assign out_echo_char    = acc_r.echo_char;
  assign out_number_done  = acc_r.number_done;
  assign out_number_value = acc_r.number_value;

  // an echo or a finished number only comes with a released key
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_echo_valid || out_number_done) |-> out_key_valid)
    else $error("echo or number without a key release");

  // a digit and a terminator cannot both be acted on in one transaction
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_echo_valid && out_number_done))
    else $error("echo and number done together");

  // a released key always returns to driving all rows low
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_key_valid |-> out_row_drive == 4'h0)
    else $error("row drive not idle on release");

  // during the row search exactly one row is driven low
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_row_drive != 4'h0) |-> $countones(out_row_drive) == 3)
    else $error("more than one row driven during search");

endmodule
`default_nettype wire

FILE: rtl/mkne_accum.sv
// decimal number accumulator and echo generation for a released key
`timescale 1ns / 1ps
`default_nettype none
module mkne_accum #(
  parameter int NUMBER_WIDTH = 32
) (
  input  wire logic                    key_en,
  input  wire logic [7:0]              key,
  input  wire logic                    echo_digits,
  input  wire logic [NUMBER_WIDTH-1:0] num,
  output logic [NUMBER_WIDTH-1:0]      num_nxt,
  output mkne_pkg::acc_res_t           res
);

  logic                    is_digit;
  logic [7:0]              digit;
  logic [NUMBER_WIDTH-1:0] num_x10;

  assign is_digit = (key >= mkne_pkg::CHAR_ZERO) && (key <= mkne_pkg::CHAR_NINE);
  assign digit    = key - mkne_pkg::CHAR_ZERO;
  assign num_x10  = (num << 3) + (num << 1);

  always_comb begin
    num_nxt = num;
    res     = '0;
    if (key_en) begin
      if (is_digit) begin
        num_nxt        = num_x10 + NUMBER_WIDTH'(digit);
        res.echo_valid = 1'b1;
        res.echo_char  = echo_digits ? key : mkne_pkg::CHAR_STAR;
      end else if (key == mkne_pkg::CHAR_HASH) begin
        num_nxt          = '0;
        res.number_done  = 1'b1;
        res.number_value = 32'(num);
      end
    end
  end

endmodule
`default_nettype wire

FILE: tb/keypad_entry_checker.sv
// checker for the keypad number entry block: predicts each scan result and compares it
`timescale 1ns / 1ps
module keypad_entry_checker
  import mkne_pkg::*;
#(
  parameter int NUMBER_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [3:0]  in_column_levels,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [3:0]  out_row_drive,
  input  wire logic        out_key_valid,
  input  wire logic [7:0]  out_key_code,
  input  wire logic        out_echo_valid,
  input  wire logic [7:0]  out_echo_char,
  input  wire logic        out_number_done,
  input  wire logic [31:0] out_number_value,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic        cfg_echo_digits,
  output int               mismatch_total,
  output int               pending_results
);

  typedef enum logic [1:0] {
    WAIT_PRESS   = 2'd0,
    ROW_SEARCH   = 2'd1,
    WAIT_RELEASE = 2'd2
  } scan_phase_t;

  typedef struct packed {
    logic [3:0]  row_drive;
    logic        key_valid;
    logic [7:0]  key_code;
    logic        echo_valid;
    logic [7:0]  echo_char;
    logic        number_done;
    logic [31:0] number_value;
  } scan_result_t;

  // row-major key layout, row 0 first
  localparam logic [8*16-1:0] KEY_LAYOUT = "123A456B789C*0#D";

  scan_phase_t             phase;
  logic [1:0]              search_row;
  logic [7:0]              held_key;
  logic [NUMBER_WIDTH-1:0] entered_number;
  logic                    echo_digits;
  scan_result_t            predicted_scans[$];

  function automatic logic [1:0] lowest_low_column(input logic [3:0] cols);
    logic [1:0] col;
    col = 2'd3;
    for (int i = 2; i >= 0; i--) begin
      if (!cols[i]) col = 2'(i);
    end
    return col;
  endfunction

  function automatic scan_result_t scan_keypad(input logic [3:0] cols);
    scan_result_t r;
    logic pressed;
    logic [7:0] k;
    r = '0;
    pressed = (cols != ALL_HIGH);
    case (phase)
      ROW_SEARCH: begin
        if (pressed) begin
          held_key = KEY_LAYOUT[8*(15 - {search_row, lowest_low_column(cols)}) +: 8];
          phase = WAIT_RELEASE;
        end else if (search_row == 2'd3) begin
          search_row = 2'd0;
          phase = WAIT_PRESS;
        end else begin
          search_row = search_row + 2'd1;
          r.row_drive = ~(4'b0001 << search_row);
        end
      end
      WAIT_RELEASE: begin
        if (!pressed) begin
          k = held_key;
          r.key_valid = 1'b1;
          r.key_code = k;
          if (k >= CHAR_ZERO && k <= CHAR_NINE) begin
            entered_number = entered_number * 10 + NUMBER_WIDTH'(k - CHAR_ZERO);
            r.echo_valid = 1'b1;
            r.echo_char = echo_digits ? k : CHAR_STAR;
          end else if (k == CHAR_HASH) begin
            r.number_done = 1'b1;
            r.number_value = 32'(entered_number);
            entered_number = '0;
          end
          phase = WAIT_PRESS;
        end
      end
      default: begin
        phase = WAIT_PRESS;
        if (pressed) begin
          search_row = 2'd0;
          phase = ROW_SEARCH;
          r.row_drive = 4'b1110;
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin : check_scans
    scan_result_t want;
    scan_result_t got;
    if (!rst_n) begin
      phase = WAIT_PRESS;
      search_row = 2'd0;
      held_key = 8'd0;
      entered_number = '0;
      echo_digits = 1'b0;
      mismatch_total = 0;
      predicted_scans.delete();
    end else begin
      if (cfg_valid && cfg_ready) echo_digits = cfg_echo_digits;
      if (out_valid && !out_stall) begin
        got = {out_row_drive, out_key_valid, out_key_code, out_echo_valid, out_echo_char,
               out_number_done, out_number_value};
        if (predicted_scans.size() == 0) begin
          if (mismatch_total < 10)
            $display("unexpected result transaction: row %h key %b/%h echo %b/%h done %b/%h",
                     got.row_drive, got.key_valid, got.key_code, got.echo_valid,
                     got.echo_char, got.number_done, got.number_value);
          mismatch_total++;
        end else begin
          want = predicted_scans.pop_front();
          if (got !== want) begin
            if (mismatch_total < 10) begin
              $display("mismatch expected: row %h key %b/%h echo %b/%h done %b/%h",
                       want.row_drive, want.key_valid, want.key_code, want.echo_valid,
                       want.echo_char, want.number_done, want.number_value);
              $display("         actual:   row %h key %b/%h echo %b/%h done %b/%h",
                       got.row_drive, got.key_valid, got.key_code, got.echo_valid,
                       got.echo_char, got.number_done, got.number_value);
            end
            mismatch_total++;
          end
        end
      end
      if (in_valid && !in_stall) predicted_scans.push_back(scan_keypad(in_column_levels));
    end
    pending_results <= predicted_scans.size();
  end

endmodule

FILE: tb/matrix_keypad_number_entry_test.sv
// testbench top for the keypad number entry block: stimulus, stalls and verdict
`timescale 1ns / 1ps
module matrix_keypad_number_entry_test;
  import mkne_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 322;
  localparam logic [3:0] HASH_SLOT = 4'd14;
  localparam logic [9:0][3:0] DIGIT_SLOTS =
    {4'd13, 4'd10, 4'd9, 4'd8, 4'd6, 4'd5, 4'd4, 4'd2, 4'd1, 4'd0};
  localparam logic [4:0][3:0] OTHER_SLOTS = {4'd15, 4'd12, 4'd11, 4'd7, 4'd3};

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [3:0]  in_column_levels;
  logic        out_valid;
  logic        out_stall;
  logic [3:0]  out_row_drive;
  logic        out_key_valid;
  logic [7:0]  out_key_code;
  logic        out_echo_valid;
  logic [7:0]  out_echo_char;
  logic        out_number_done;
  logic [31:0] out_number_value;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_echo_digits;

  int mismatch_total;
  int pending_results;
  int scans_sent = 0;
  int quiet_cycles = 0;
  bit sender_fast = 1'b0;
  bit receiver_fast = 1'b0;
  bit hold_outputs = 1'b0;

  always #4 clk = ~clk;

  matrix_keypad_number_entry i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_column_levels (in_column_levels),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_row_drive    (out_row_drive),
    .out_key_valid    (out_key_valid),
    .out_key_code     (out_key_code),
    .out_echo_valid   (out_echo_valid),
    .out_echo_char    (out_echo_char),
    .out_number_done  (out_number_done),
    .out_number_value (out_number_value),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_echo_digits  (cfg_echo_digits)
  );

  keypad_entry_checker i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_column_levels (in_column_levels),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_row_drive    (out_row_drive),
    .out_key_valid    (out_key_valid),
    .out_key_code     (out_key_code),
    .out_echo_valid   (out_echo_valid),
    .out_echo_char    (out_echo_char),
    .out_number_done  (out_number_done),
    .out_number_value (out_number_value),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_echo_digits  (cfg_echo_digits),
    .mismatch_total   (mismatch_total),
    .pending_results  (pending_results)
  );

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // result receiver: random stall before each transaction, one long hold-off on request
  initial begin
    int pause;
    out_stall = 1'b0;
    forever begin
      if (hold_outputs) begin
        pause = HOLD_CYCLES;
        hold_outputs = 1'b0;
      end else begin
        if ($urandom_range(0, 31) == 0) receiver_fast = ~receiver_fast;
        pause = receiver_fast ? 0 : $urandom_range(0, 16);
      end
      @(negedge clk);
      if (pause > 0) begin
        out_stall <= 1'b1;
        repeat (pause) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic send_levels(input logic [3:0] levels);
    int gap;
    if ($urandom_range(0, 31) == 0) sender_fast = ~sender_fast;
    gap = sender_fast ? 0 : $urandom_range(0, 16);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_column_levels <= levels;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    scans_sent++;
  endtask

  task automatic go_quiet();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_results != 0) @(negedge clk);
  endtask

  task automatic write_echo_mode(input logic mode);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_echo_digits <= mode;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [3:0] any_press();
    return 4'($urandom_range(0, 14));
  endfunction

  function automatic logic [3:0] column_low(input int col);
    logic [3:0] levels;
    levels = 4'($urandom);
    for (int i = 0; i < col; i++) levels[i] = 1'b1;
    levels[col] = 1'b0;
    return levels;
  endfunction

  // press, row search down to the key's row, optional hold, release
  task automatic enter_key(input logic [3:0] slot);
    send_levels(any_press());
    repeat (int'(slot[3:2])) send_levels(ALL_HIGH);
    send_levels(column_low(int'(slot[1:0])));
    repeat ($urandom_range(0, 3)) send_levels(any_press());
    send_levels(ALL_HIGH);
  endtask

  task automatic random_action();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 2) begin
      repeat ($urandom_range(1, 4)) send_levels(4'($urandom));
      repeat (4) send_levels(ALL_HIGH);
    end else if (pick == 2) begin
      send_levels(any_press());
      repeat (4) send_levels(ALL_HIGH);
    end else if (pick == 3) begin
      enter_key(HASH_SLOT);
    end else if (pick == 4) begin
      enter_key(OTHER_SLOTS[$urandom_range(0, 4)]);
    end else begin
      enter_key(DIGIT_SLOTS[$urandom_range(0, 9)]);
    end
  endtask

  initial begin
    int phase_end;
    bit paused;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_column_levels = ALL_HIGH;
    cfg_valid = 1'b0;
    cfg_echo_digits = 1'b0;
    paused = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // all columns low: lowest column wins, key 1
    send_levels(4'b0000);
    send_levels(4'b0000);
    send_levels(4'b0101);
    send_levels(ALL_HIGH);
    // key 0 on the last row
    send_levels(4'b1101);
    repeat (3) send_levels(ALL_HIGH);
    send_levels(4'b1101);
    send_levels(ALL_HIGH);
    // key D, ignored
    send_levels(4'b0111);
    repeat (3) send_levels(ALL_HIGH);
    send_levels(4'b0111);
    send_levels(ALL_HIGH);
    // hash ends the number
    send_levels(4'b1011);
    repeat (3) send_levels(ALL_HIGH);
    send_levels(4'b1011);
    send_levels(ALL_HIGH);
    // press gone during row search: no row found
    send_levels(4'b1110);
    repeat (4) send_levels(ALL_HIGH);

    for (int p = 0; p < PHASES; p++) begin
      go_quiet();
      wait_drained();
      write_echo_mode(1'(p % 2));
      if (p == 1) hold_outputs = 1'b1;
      phase_end = scans_sent + PHASE_ITEMS;
      while (scans_sent < phase_end) begin
        if (p == 2 && !paused && scans_sent >= phase_end - PHASE_ITEMS / 2) begin
          go_quiet();
          wait_drained();
          paused = 1'b1;
        end
        random_action();
      end
    end

    go_quiet();
    wait_drained();
    repeat (4) @(negedge clk);
    if (mismatch_total == 0 && pending_results == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: matrix_keypad_number_entry.f
rtl/mkne_pkg.sv
rtl/mkne_accum.sv
rtl/matrix_keypad_number_entry.sv
tb/keypad_entry_checker.sv
tb/matrix_keypad_number_entry_test.sv
